// ===== hw/rtl/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// frac_pkg
// Shared width constants and item types for the fraction reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package frac_pkg;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic signed [WIDTH-1:0] numerator;
        logic signed [WIDTH-1:0] denominator;
    } frac_in_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] reduced_numerator;
        logic signed [WIDTH-1:0] reduced_denominator;
        logic                    whole_number;
    } frac_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fraction_reducer.sv =====
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a signed fraction to lowest terms with a binary gcd and a shared
// shift-register restoring divider.
// ----------------------------------------------------------------------------
//   channel  ports                      item
//   input    s_valid s_ready s_data     frac_in_t  (numerator, denominator)
//   result   m_valid m_ready m_data     frac_out_t (reduced parts, whole flag)
//
// one item at a time: each item runs the common-factor shift, the gcd
// subtract loop and two divisions on the shared divider in turn; a zero
// numerator or denominator goes straight to the result state
// synchronous active-low reset clears the state machine and the result valid
// the result sits in an output register, so a stalled m_ready only holds
// the next item once its result is ready to load
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reducer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire frac_pkg::frac_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output frac_pkg::frac_out_t     m_data
);
    import frac_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVEN = 6'b000010,
        ST_GCD  = 6'b000100,
        ST_DIVN = 6'b001000,
        ST_DIVD = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [WIDTH-1:0]  num_reg, num_next;
    logic [WIDTH-1:0]  den_reg, den_next;
    logic [WIDTH-1:0]  a_reg, a_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic [WIDTH-1:0]  dvd_reg, dvd_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_n_reg, neg_n_next;
    logic              neg_d_reg, neg_d_next;
    logic              m_valid_reg, m_valid_next;
    frac_out_t         m_data_reg, m_data_next;

    logic [WIDTH-1:0]  mag_n, mag_d;
    logic [WIDTH:0]    diff_ab;
    logic [WIDTH-1:0]  diff_ba;
    logic [WIDTH-1:0]  trial;
    logic [WIDTH:0]    trial_sub;
    logic              q_bit;
    logic [WIDTH-1:0]  rem_step, dvd_step;
    logic              cnt_last;
    logic              out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign mag_n = s_data.numerator[WIDTH-1] ? (~s_data.numerator + 1'b1)
                                             : s_data.numerator;
    assign mag_d = s_data.denominator[WIDTH-1] ? (~s_data.denominator + 1'b1)
                                               : s_data.denominator;

    assign diff_ab = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba = b_reg - a_reg;

    // one quotient bit per cycle, divisor is the odd gcd in a_reg
    assign trial     = {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};
    assign trial_sub = {1'b0, trial} - {1'b0, a_reg};
    assign q_bit     = !trial_sub[WIDTH];
    assign rem_step  = q_bit ? trial_sub[WIDTH-1:0] : trial;
    assign dvd_step  = {dvd_reg[WIDTH-2:0], q_bit};
    assign cnt_last  = (cnt_reg == CNT_W'(WIDTH - 1));

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        neg_n_next   = neg_n_reg;
        neg_d_next   = neg_d_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_n_next = s_data.numerator[WIDTH-1];
                    neg_d_next = s_data.denominator[WIDTH-1];
                    priority if (mag_d == '0) begin
                        num_next   = '0;
                        den_next   = '0;
                        neg_n_next = 1'b0;
                        neg_d_next = 1'b0;
                        state_next = ST_FIN;
                    end else if (mag_n == '0) begin
                        num_next   = '0;
                        den_next   = WIDTH'(1);
                        neg_n_next = 1'b0;
                        neg_d_next = 1'b0;
                        state_next = ST_FIN;
                    end else begin
                        num_next   = mag_n;
                        den_next   = mag_d;
                        state_next = ST_EVEN;
                    end
                end
            end
            ST_EVEN: begin
                // strip the common power of two from both parts
                if (!num_reg[0] && !den_reg[0]) begin
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end else begin
                    a_next     = num_reg;
                    b_next     = den_reg;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                priority if (diff_ab == '0) begin
                    dvd_next   = num_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (!diff_ab[WIDTH]) begin
                    a_next = diff_ab[WIDTH-1:0] >> 1;
                end else begin
                    b_next = diff_ba >> 1;
                end
            end
            ST_DIVN: begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    num_next   = dvd_step;
                    dvd_next   = den_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    den_next   = dvd_step;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_next.reduced_numerator =
                        (neg_n_reg && !neg_d_reg) ? (~num_reg + 1'b1) : num_reg;
                    m_data_next.reduced_denominator =
                        (neg_d_reg && !neg_n_reg) ? (~den_reg + 1'b1) : den_reg;
                    m_data_next.whole_number = (den_reg == WIDTH'(1));
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        den_reg    <= den_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_n_reg  <= neg_n_next;
        neg_d_reg  <= neg_d_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/frac_checker.sv =====
// ----------------------------------------------------------------------------
// frac_checker
// Port-level checks for the fraction reducer, bound into every fraction_reducer.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire frac_pkg::frac_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire frac_pkg::frac_out_t m_data
);
    import frac_pkg::*;

    logic [WIDTH-1:0] den_bits;
    logic [WIDTH-1:0] num_bits;

    assign den_bits = m_data.reduced_denominator;
    assign num_bits = m_data.reduced_numerator;

    // a result stays up until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    // one item in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in flight");

    // whole flag only with a unit denominator
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.whole_number |->
            den_bits == WIDTH'(1) || den_bits == '1)
        else $error("whole flag set without unit denominator");

    // zero denominator only comes out as the all-zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && den_bits == '0 |-> num_bits == '0 && !m_data.whole_number)
        else $error("zero denominator with nonzero result fields");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind fraction_reducer frac_checker u_frac_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fraction_reducer. Fractions go in through a
// queue-fed driver with random valid gaps. The result side is back-pressured
// with random ready stalls. Each accepted item is reduced by a local gcd
// model, and every result is compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frac_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = ~MOST_NEG;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    frac_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    frac_out_t m_data;

    frac_in_t  pending_fractions[$];
    frac_out_t expected_fractions[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        in_gap = 0;
    int        out_hold = 0;
    logic      in_taken = 1'b0;
    logic      steady = 1'b0;

    fraction_reducer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic frac_out_t reduce_fraction(frac_in_t f);
        logic [WIDTH-1:0] mag_n, mag_d, x, y, r, qn, qd;
        logic             neg_n, neg_d;
        frac_out_t        res;
        neg_n = f.numerator[WIDTH-1];
        neg_d = f.denominator[WIDTH-1];
        mag_n = f.numerator;
        mag_d = f.denominator;
        if (neg_n) mag_n = ~mag_n + 1'b1;
        if (neg_d) mag_d = ~mag_d + 1'b1;
        res = '0;
        if (mag_d == 0) begin
            return res;
        end
        if (mag_n == 0) begin
            res.reduced_denominator = 1;
            res.whole_number = 1'b1;
            return res;
        end
        x = mag_n;
        y = mag_d;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        qn = mag_n / x;
        qd = mag_d / x;
        if (neg_n && neg_d) begin
            neg_n = 1'b0;
            neg_d = 1'b0;
        end
        res.reduced_numerator = neg_n ? ~qn + 1'b1 : qn;
        res.reduced_denominator = neg_d ? ~qd + 1'b1 : qd;
        res.whole_number = (qd == 1);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 39) == 0) steady = ~steady;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WIDTH-1:0] rand_bits(int max_bits);
        int n;
        n = $urandom_range(1, max_bits);
        return WIDTH'($urandom & ((33'd1 << n) - 1'b1));
    endfunction

    function automatic frac_in_t random_fraction();
        logic [WIDTH-1:0] n, d, g, extremes[6];
        int               kind;
        frac_in_t         f;
        extremes = '{MOST_NEG, MOST_POS, ~MOST_POS + 1'b1, 1, '1, 0};
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom;
            d = $urandom;
        end else if (kind < 60) begin
            // shared random factor, so the gcd is usually nontrivial
            g = rand_bits(12);
            n = rand_bits(16) * g;
            d = rand_bits(16) * g;
        end else if (kind < 75) begin
            n = $urandom_range(0, 20);
            d = $urandom_range(0, 20);
        end else if (kind < 85) begin
            n = (32'd1 << $urandom_range(0, 31)) * rand_bits(6);
            d = (32'd1 << $urandom_range(0, 31)) * rand_bits(6);
        end else if (kind < 92) begin
            // denominator divides numerator
            d = rand_bits(14);
            n = d * rand_bits(16);
        end else begin
            n = extremes[$urandom_range(0, 5)];
            d = $urandom_range(0, 1) ? extremes[$urandom_range(0, 5)] : rand_bits(32);
        end
        if ($urandom_range(0, 1)) n = -n;
        if ($urandom_range(0, 1)) d = -d;
        f.numerator = n;
        f.denominator = d;
        return f;
    endfunction

    task automatic add_fraction(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] d);
        frac_in_t f;
        f.numerator = n;
        f.denominator = d;
        pending_fractions.push_back(f);
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // driver and ready pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (in_gap != 0) begin
                    in_gap <= in_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_fractions.size() != 0) begin
                    s_data <= pending_fractions.pop_front();
                    s_valid <= 1'b1;
                    in_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (out_hold != 0) begin
                out_hold <= out_hold - 1;
            end else if (m_ready) begin
                int stall;
                stall = pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    out_hold <= stall - 1;
                end
            end else begin
                m_ready <= 1'b1;
                out_hold <= $urandom_range(0, 12);
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : monitor
        frac_out_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) expected_fractions.push_back(reduce_fraction(s_data));
            if (m_valid && m_ready) begin
                if (expected_fractions.size() == 0) begin
                    note_failure($sformatf("unexpected item: %0d/%0d whole %0b",
                        m_data.reduced_numerator, m_data.reduced_denominator,
                        m_data.whole_number));
                end else begin
                    want = expected_fractions.pop_front();
                    if (m_data.reduced_numerator !== want.reduced_numerator ||
                        m_data.reduced_denominator !== want.reduced_denominator ||
                        m_data.whole_number !== want.whole_number) begin
                        note_failure($sformatf(
                            "mismatch: expected %0d/%0d whole %0b, got %0d/%0d whole %0b",
                            want.reduced_numerator, want.reduced_denominator,
                            want.whole_number, m_data.reduced_numerator,
                            m_data.reduced_denominator, m_data.whole_number));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // zero numerator and zero denominator
        add_fraction(0, 5);
        add_fraction(0, -7);
        add_fraction(0, MOST_NEG);
        add_fraction(0, 0);
        add_fraction(9, 0);
        add_fraction(MOST_NEG, 0);
        // sign handling
        add_fraction(6, 4);
        add_fraction(-6, 4);
        add_fraction(6, -4);
        add_fraction(-6, -4);
        add_fraction(12, -4);
        add_fraction(-12, -4);
        add_fraction(1, 1);
        add_fraction(-1, -1);
        // most negative operand, including the wrap to itself
        add_fraction(MOST_NEG, 1);
        add_fraction(MOST_NEG, -1);
        add_fraction(MOST_NEG, -2);
        add_fraction(1, MOST_NEG);
        add_fraction(MOST_NEG, MOST_NEG);
        add_fraction(MOST_NEG, MOST_POS);
        add_fraction(MOST_POS, MOST_POS);
        add_fraction(-MOST_POS, MOST_POS);
        add_fraction(MOST_POS, -1);
        add_fraction(1, MOST_POS);
        add_fraction(2147483629, 2147483587);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_fractions.push_back(random_fraction());
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_fractions.size() != 0 || s_valid) @(posedge aclk);
        while (expected_fractions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/frac_pkg.sv
hw/rtl/fraction_reducer.sv
hw/rtl/frac_checker.sv
tb/tb.sv
